FILE: sv/aisds_pkg.sv
package aisds_pkg;

  localparam int SAMPLE_W      = 10;
  localparam int OUT_W         = 16;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 16;
  localparam int IN_TDATA_W    = 16;

  localparam int AVG_SHIFT     = 3;
  localparam int AVG_COUNT     = 1 << AVG_SHIFT;
  localparam int SUM_W         = SAMPLE_W + AVG_SHIFT;

  localparam int SPAN_W        = SAMPLE_W + 1;
  localparam int OSPAN_X_W     = OUT_W + 1;
  localparam int PROD_W        = SPAN_W + OSPAN_X_W;
  localparam int MAG_W         = 26;
  localparam int BITS_PER_STEP = 2;
  localparam int DIV_STEPS     = MAG_W / BITS_PER_STEP;
  localparam int CNT_W         = $clog2(DIV_STEPS);

  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 10'd1023;
  localparam logic [SAMPLE_W-1:0] ZERO_FLOOR = 10'd5;

  localparam logic [MAG_W-1:0] SAT_POS_MAG = 26'd32767;
  localparam logic [MAG_W-1:0] SAT_NEG_MAG = 26'd32768;
  localparam logic [OUT_W-1:0] SAT_POS     = 16'h7fff;
  localparam logic [OUT_W-1:0] SAT_NEG     = 16'h8000;

  localparam logic [CFG_IDX_W-1:0] REG_SPAN_LOW      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPAN_HIGH     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_SPAN      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT_INPUT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CHANGE_MARGIN = 3'd4;

  localparam logic [SAMPLE_W-1:0] SPAN_LOW_RST      = 10'd0;
  localparam logic [SAMPLE_W-1:0] SPAN_HIGH_RST     = 10'd1023;
  localparam logic [OUT_W-1:0]    OUT_SPAN_RST      = 16'd127;
  localparam logic [SAMPLE_W-1:0] CHANGE_MARGIN_RST = 10'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AVG,
    ST_MUL,
    ST_PREP,
    ST_DIV,
    ST_SAT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load_in;
    logic step_avg;
    logic step_mul;
    logic div_init;
    logic div_step;
    logic sat;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic changed;
    logic need_div;
  } status_t;

endpackage

FILE: sv/aisds_ctrl.sv
module aisds_ctrl
  import aisds_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  output logic    in_tready,
  output logic    out_tvalid,
  input  logic    out_tready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;

  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign in_tready  = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd           = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_AVG;
        end
      end
      ST_AVG: begin
        cmd.step_avg = 1'b1;
        state_nxt    = status.changed ? ST_MUL : ST_OUT;
      end
      ST_MUL: begin
        cmd.step_mul = 1'b1;
        state_nxt    = status.need_div ? ST_PREP : ST_OUT;
      end
      ST_PREP: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = CNT_W'(DIV_STEPS - 1);
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_SAT;
        end
      end
      ST_SAT: begin
        cmd.sat   = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: sv/aisds_dp.sv
module aisds_dp
  import aisds_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [SAMPLE_W-1:0]   sample,
  input  cmd_t                  cmd,
  output status_t               status,
  output logic                  out_changed,
  output logic [OUT_W-1:0]      out_scaled
);

  logic [SAMPLE_W-1:0] span_low_r, span_high_r, margin_r;
  logic [OUT_W-1:0]    out_span_r;
  logic                invert_r;

  logic [SAMPLE_W-1:0] s_r;
  logic [SAMPLE_W-1:0] avg_r, rep_r;
  logic [OUT_W-1:0]    held_r;
  logic                chg_r;

  logic signed [PROD_W-1:0] prod_r;
  logic                     span_neg_r;
  logic [SAMPLE_W-1:0]      dvs_r;
  logic [SAMPLE_W-1:0]      rem_r, rem_nxt;
  logic [MAG_W-1:0]         dvd_r, dvd_nxt;
  logic                     neg_r;
  logic [OUT_W-1:0]         out_scaled_r;
  logic                     out_changed_r;

  logic [SUM_W-1:0]          avg_sum;
  logic [SAMPLE_W-1:0]       avg_calc;
  logic signed [SAMPLE_W+1:0] db_diff, db_thr;
  logic                      changed;

  logic signed [SPAN_W-1:0]    span, avg_off;
  logic signed [OSPAN_X_W-1:0] span_x, ospan_x;
  logic                        pass, zero_span;
  logic signed [PROD_W-1:0]    prod;
  logic [PROD_W-1:0]           prod_abs;
  logic [SPAN_W-1:0]           span_abs;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      span_low_r  <= SPAN_LOW_RST;
      span_high_r <= SPAN_HIGH_RST;
      out_span_r  <= OUT_SPAN_RST;
      invert_r    <= 1'b0;
      margin_r    <= CHANGE_MARGIN_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SPAN_LOW:      span_low_r  <= cfg_data[SAMPLE_W-1:0];
        REG_SPAN_HIGH:     span_high_r <= cfg_data[SAMPLE_W-1:0];
        REG_OUT_SPAN:      out_span_r  <= cfg_data[OUT_W-1:0];
        REG_INVERT_INPUT:  invert_r    <= cfg_data[0];
        REG_CHANGE_MARGIN: margin_r    <= cfg_data[SAMPLE_W-1:0];
        default: ;
      endcase
    end
  end

  // smoothing and deadband
  assign avg_sum  = SUM_W'(avg_r) * SUM_W'(AVG_COUNT - 1) + SUM_W'(s_r);
  assign avg_calc = avg_sum[SUM_W-1:AVG_SHIFT];
  assign db_diff  = $signed({2'b00, avg_calc}) - $signed({2'b00, rep_r});
  assign db_thr   = $signed({2'b00, margin_r});
  assign changed  = (db_diff > db_thr) || (db_diff < -db_thr);

  // rescale setup
  assign span      = $signed({1'b0, span_high_r}) - $signed({1'b0, span_low_r});
  assign span_x    = OSPAN_X_W'(span);
  assign ospan_x   = $signed({1'b0, out_span_r});
  assign pass      = (span_x == ospan_x);
  assign zero_span = (span == '0);
  assign avg_off   = $signed({1'b0, avg_r}) - $signed({1'b0, span_low_r});
  assign prod      = avg_off * ospan_x;
  assign prod_abs  = prod_r[PROD_W-1] ? PROD_W'(-prod_r) : PROD_W'(prod_r);
  assign span_abs  = span[SPAN_W-1] ? SPAN_W'(-span) : SPAN_W'(span);

  assign status.changed  = changed;
  assign status.need_div = !pass && !zero_span;

  // restoring divide, two quotient bits per cycle
  always_comb begin
    logic [SAMPLE_W:0] part;
    logic              ge;
    rem_nxt = rem_r;
    dvd_nxt = dvd_r;
    for (int i = 0; i < BITS_PER_STEP; i++) begin
      part    = {rem_nxt, dvd_nxt[MAG_W-1]};
      ge      = (part >= {1'b0, dvs_r});
      if (ge) begin
        part = part - {1'b0, dvs_r};
      end
      rem_nxt = part[SAMPLE_W-1:0];
      dvd_nxt = {dvd_nxt[MAG_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avg_r  <= '0;
      rep_r  <= '0;
      held_r <= '0;
    end else begin
      if (cmd.step_avg) begin
        if (changed) begin
          rep_r <= avg_calc;
          avg_r <= (avg_calc <= ZERO_FLOOR) ? '0 : avg_calc;
        end else begin
          avg_r <= avg_calc;
        end
      end
      if (cmd.step_mul) begin
        if (pass) begin
          held_r <= OUT_W'(avg_r);
        end else if (zero_span) begin
          held_r <= '0;
        end
      end
      if (cmd.sat) begin
        if (!neg_r) begin
          held_r <= (dvd_r > SAT_POS_MAG) ? SAT_POS : dvd_r[OUT_W-1:0];
        end else begin
          held_r <= (dvd_r > SAT_NEG_MAG) ? SAT_NEG : OUT_W'(-dvd_r[OUT_W-1:0]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      s_r <= invert_r ? (SAMPLE_MAX - sample) : sample;
    end
    if (cmd.step_avg) begin
      chg_r <= changed;
    end
    if (cmd.step_mul) begin
      prod_r     <= prod;
      span_neg_r <= span[SPAN_W-1];
      dvs_r      <= span_abs[SAMPLE_W-1:0];
    end
    if (cmd.div_init) begin
      dvd_r <= prod_abs[MAG_W-1:0];
      rem_r <= '0;
      neg_r <= prod_r[PROD_W-1] ^ span_neg_r;
    end
    if (cmd.div_step) begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
    end
    if (cmd.out_load) begin
      out_changed_r <= chg_r;
      out_scaled_r  <= held_r;
    end
  end

  assign out_changed = out_changed_r;
  assign out_scaled  = out_scaled_r;

endmodule

FILE: sv/analog_input_smooth_deadband_scale.sv
// each accepted input is averaged, then sent straight out when the deadband
// holds, set directly when it is a pass-through or zero span, or else divided
// by the radix-4 divider; no new item is taken until its result is output
// an output waiting on out_tready stalls the next item only at its result stage
// reset: synchronous active-low rst_n clears average, reference, held value
// and loads register defaults
module analog_input_smooth_deadband_scale
  import aisds_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,   // [9:0] sample, [15:10] zero
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_W-1:0]      out_tdata,  // [15:0] scaled_value
  output logic                  out_tuser,  // [0] changed
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  aisds_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  aisds_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .sample      (in_tdata[SAMPLE_W-1:0]),
    .cmd         (cmd),
    .status      (status),
    .out_changed (out_tuser),
    .out_scaled  (out_tdata)
  );

endmodule

FILE: sv/aisds_chk.sv
module aisds_chk
  import aisds_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_W-1:0]      out_tdata,
  input logic                  out_tuser
);

  logic [OUT_W-1:0] last_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_out_r <= '0;
    end else if (out_tvalid && out_tready) begin
      last_out_r <= out_tdata;
    end
  end

  // stalled output holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("output changed while stalled");

  // no change repeats the held value
  a_no_change_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == last_out_r)
    else $error("unchanged item altered scaled value");

  // one item in flight
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item taken while busy");

  a_reset_quiet: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind analog_input_smooth_deadband_scale aisds_chk u_aisds_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
